[rtl/erm_pkg.sv]
// Package for the event rate monitor: field widths, constants, sequencer
// state types and the request/response structs of the shared divider.
// No dependencies; every other file refers to it by scoped names.
package erm_pkg;

   localparam int TIME_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int SEQ_W      = 32;
   localparam int INTERVAL_W = 48;
   localparam int EVENTS_W   = 48;
   localparam int RES_W      = 32;

   // Scale from events per ns to kilo-events per second.
   localparam int               SCALE_W = 20;
   localparam logic [SCALE_W-1:0] SCALE = 20'd1000000;
   localparam int               MUL_A_W = 32;
   localparam int               MUL_W   = MUL_A_W + SCALE_W;

   // Largest dividend: window events times the scale (48 + 20 bits).
   localparam int DVD_W = EVENTS_W + SCALE_W;
   localparam int DVS_W = 64;
   localparam int QUOT_W = 32;
   localparam int CNT_W = $clog2(QUOT_W);

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 48'd1000000000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RATE_MUL,
      S_RATE_DIV,
      S_RATE_WAIT,
      S_ACCUM,
      S_TEST,
      S_AVG_DIV,
      S_AVG_WAIT,
      S_EVLO_MUL,
      S_EVHI_MUL,
      S_AR_DIV,
      S_AR_WAIT,
      S_EMIT
   } ctl_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/erm_ifs.sv]
// Channel interfaces of the event rate monitor: message input, report
// output and the interval register write port. Depends on erm_pkg.
interface erm_req_if;
   logic                            valid;
   logic                            ready;
   logic [erm_pkg::TIME_W-1:0]      start_time_ns;
   logic [erm_pkg::TIME_W-1:0]      end_time_ns;
   logic [erm_pkg::COUNT_W-1:0]     event_count;
   logic [erm_pkg::SEQ_W-1:0]       seq_number;

   modport source(output valid, start_time_ns, end_time_ns, event_count, seq_number,
                  input ready);
   modport sink(input valid, start_time_ns, end_time_ns, event_count, seq_number,
                output ready);
endinterface

interface erm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [erm_pkg::RES_W-1:0]   avg_events_per_msg;
   logic [erm_pkg::RES_W-1:0]   avg_rate_kevs;
   logic [erm_pkg::RES_W-1:0]   max_rate_kevs;
   logic [erm_pkg::RES_W-1:0]   dropped_count;

   modport source(output valid, avg_events_per_msg, avg_rate_kevs, max_rate_kevs,
                  dropped_count, input ready);
   modport sink(input valid, avg_events_per_msg, avg_rate_kevs, max_rate_kevs,
                dropped_count, output ready);
endinterface

interface erm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [erm_pkg::INTERVAL_W-1:0]   wdata;

   modport source(output valid, wdata, input ready);
   modport sink(input valid, wdata, output ready);
endinterface

[rtl/erm_div.sv]
// Shared restoring divider: 68-bit dividend over 64-bit divisor, one quotient
// bit per cycle, quotient saturated to 32 bits and 0 for a zero divisor.
// Depends on erm_pkg.
module erm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  erm_pkg::div_req_type div_req,
   output erm_pkg::div_rsp_type div_rsp
);

   erm_pkg::div_state_type state_ff, state_in;

   logic [erm_pkg::DVD_W-1:0]  dvd_ff;
   logic [erm_pkg::DVS_W-1:0]  dvs_ff;
   logic [erm_pkg::DVS_W-1:0]  rem_ff;
   logic [erm_pkg::QUOT_W-1:0] lo_ff;
   logic [erm_pkg::CNT_W-1:0]  cnt_ff;

   logic [erm_pkg::DVS_W:0]    shifted;
   logic [erm_pkg::DVS_W:0]    diff;
   logic                       take;
   logic                       dvs_zero;
   logic                       too_big;

   assign shifted  = {rem_ff, lo_ff[erm_pkg::QUOT_W-1]};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign take     = !diff[erm_pkg::DVS_W];
   assign dvs_zero = (dvs_ff == '0);
   // The quotient overflows 32 bits when the dividend reaches divisor * 2^32.
   assign too_big  = ({{(erm_pkg::DVS_W + erm_pkg::QUOT_W - erm_pkg::DVD_W){1'b0}}, dvd_ff}
                      >= {dvs_ff, {erm_pkg::QUOT_W{1'b0}}});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         erm_pkg::DIV_IDLE: begin
            if (div_req.start) state_in = erm_pkg::DIV_CHECK;
         end
         erm_pkg::DIV_CHECK: begin
            if (dvs_zero || too_big) state_in = erm_pkg::DIV_DONE;
            else state_in = erm_pkg::DIV_RUN;
         end
         erm_pkg::DIV_RUN: begin
            if (cnt_ff == '0) state_in = erm_pkg::DIV_DONE;
         end
         erm_pkg::DIV_DONE: begin
            state_in = erm_pkg::DIV_IDLE;
         end
         default: state_in = erm_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      div_rsp.busy     = (state_ff != erm_pkg::DIV_IDLE);
      div_rsp.done     = (state_ff == erm_pkg::DIV_DONE);
      div_rsp.quotient = lo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erm_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         erm_pkg::DIV_IDLE: begin
            if (div_req.start) begin
               dvd_ff <= div_req.dividend;
               dvs_ff <= div_req.divisor;
            end
         end
         erm_pkg::DIV_CHECK: begin
            cnt_ff <= erm_pkg::CNT_W'(erm_pkg::QUOT_W - 1);
            if (dvs_zero) begin
               lo_ff <= '0;
            end else if (too_big) begin
               lo_ff <= '1;
            end else begin
               rem_ff <= {{(erm_pkg::DVS_W - (erm_pkg::DVD_W - erm_pkg::QUOT_W)){1'b0}},
                          dvd_ff[erm_pkg::DVD_W-1:erm_pkg::QUOT_W]};
               lo_ff  <= dvd_ff[erm_pkg::QUOT_W-1:0];
            end
         end
         erm_pkg::DIV_RUN: begin
            // Remainder stays below the divisor, so 64 bits hold it after the step.
            rem_ff <= take ? diff[erm_pkg::DVS_W-1:0] : shifted[erm_pkg::DVS_W-1:0];
            lo_ff  <= {lo_ff[erm_pkg::QUOT_W-2:0], take};
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> state_ff == erm_pkg::DIV_IDLE)
      else $error("divider started while busy");

endmodule

[rtl/event_rate_monitor.sv]
// Event rate monitor top level: message sequencer, window statistics and the
// report output register around one shared divider and one 32x20 multiplier.
// Depends on erm_pkg, erm_ifs (channel interfaces) and erm_div.
//
//   channel   dir   beat contents
//   req_if    in    start_time_ns, end_time_ns, event_count, seq_number
//   rsp_if    out   avg_events_per_msg, avg_rate_kevs, max_rate_kevs, dropped_count
//   csr_if    in    wdata = report_interval_ns (always ready)
//
// A message without a report passes through RATE_MUL, RATE_DIV, RATE_WAIT, ACCUM
// and TEST between accepted beats; the shared divider's rate division dominates.
// A zero duration or a saturating rate skips the divider's quotient steps.
// A message that closes a window adds two more divisions.
// req_if.ready is high only while the sequencer is idle. A report waits in
// the output register while the next message is taken; only a second report
// stalls behind it. Synchronous reset restores the interval to 1e9 ns.
module event_rate_monitor (
   input logic         clock,
   input logic         reset,
   erm_req_if.sink     req_if,
   erm_rsp_if.source   rsp_if,
   erm_csr_if.sink     csr_if
);

   erm_pkg::ctl_state_type state_ff, state_in;
   erm_pkg::div_req_type   div_req;
   erm_pkg::div_rsp_type   div_rsp;

   logic [erm_pkg::INTERVAL_W-1:0] interval_ff;

   logic [erm_pkg::TIME_W-1:0]  start_ff;
   logic [erm_pkg::TIME_W-1:0]  end_ff;
   logic [erm_pkg::TIME_W-1:0]  dur_ff;
   logic [erm_pkg::COUNT_W-1:0] count_ff;
   logic [erm_pkg::SEQ_W-1:0]   seq_ff;

   logic [erm_pkg::RES_W-1:0]    max_rate_ff;
   logic [erm_pkg::EVENTS_W-1:0] events_ff;
   logic [erm_pkg::TIME_W-1:0]   time_ff;
   logic [erm_pkg::RES_W-1:0]    msgs_ff;
   logic [erm_pkg::RES_W-1:0]    drop_ff;
   logic [erm_pkg::SEQ_W-1:0]    prev_seq_ff;
   logic [erm_pkg::TIME_W-1:0]   wstart_ff;
   logic [erm_pkg::TIME_W-1:0]   limit_ff;

   logic [erm_pkg::MUL_W-1:0]  prod_ff;
   logic [erm_pkg::DVD_W-1:0]  wide_ff;
   logic [erm_pkg::RES_W-1:0]  avg_ev_ff;
   logic [erm_pkg::RES_W-1:0]  avg_rate_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [erm_pkg::RES_W-1:0]  rsp_avg_ev_ff;
   logic [erm_pkg::RES_W-1:0]  rsp_avg_rate_ff;
   logic [erm_pkg::RES_W-1:0]  rsp_max_ff;
   logic [erm_pkg::RES_W-1:0]  rsp_drop_ff;

   logic                          req_fire;
   logic                          emit_fire;
   logic                          report_hit;
   logic [erm_pkg::TIME_W:0]      limit_sum;
   logic [erm_pkg::MUL_A_W-1:0]   mul_a;
   logic [erm_pkg::MUL_W-1:0]     mul_p;
   logic [erm_pkg::EVENTS_W:0]    ev_sum;
   logic [erm_pkg::TIME_W:0]      time_sum;
   logic [erm_pkg::SEQ_W-1:0]     gap;
   logic [erm_pkg::RES_W:0]       drop_sum;
   logic                          restart;

   erm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------- sequencer ----------------
   assign req_fire  = req_if.valid && req_if.ready;
   assign emit_fire = (state_ff == erm_pkg::S_EMIT) && !rsp_valid_ff;

   assign limit_sum  = {1'b0, wstart_ff}
                     + {{(erm_pkg::TIME_W + 1 - erm_pkg::INTERVAL_W){1'b0}}, interval_ff};
   assign report_hit = !limit_sum[erm_pkg::TIME_W] && (end_ff > limit_sum[erm_pkg::TIME_W-1:0]);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         erm_pkg::S_IDLE:      if (req_if.valid) state_in = erm_pkg::S_RATE_MUL;
         erm_pkg::S_RATE_MUL:  state_in = erm_pkg::S_RATE_DIV;
         erm_pkg::S_RATE_DIV:  state_in = erm_pkg::S_RATE_WAIT;
         erm_pkg::S_RATE_WAIT: if (div_rsp.done) state_in = erm_pkg::S_ACCUM;
         erm_pkg::S_ACCUM:     state_in = erm_pkg::S_TEST;
         erm_pkg::S_TEST:      state_in = report_hit ? erm_pkg::S_AVG_DIV : erm_pkg::S_IDLE;
         erm_pkg::S_AVG_DIV:   state_in = erm_pkg::S_AVG_WAIT;
         erm_pkg::S_AVG_WAIT:  if (div_rsp.done) state_in = erm_pkg::S_EVLO_MUL;
         erm_pkg::S_EVLO_MUL:  state_in = erm_pkg::S_EVHI_MUL;
         erm_pkg::S_EVHI_MUL:  state_in = erm_pkg::S_AR_DIV;
         erm_pkg::S_AR_DIV:    state_in = erm_pkg::S_AR_WAIT;
         erm_pkg::S_AR_WAIT:   if (div_rsp.done) state_in = erm_pkg::S_EMIT;
         erm_pkg::S_EMIT:      if (!rsp_valid_ff) state_in = erm_pkg::S_IDLE;
         default:              state_in = erm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {{(erm_pkg::DVD_W - erm_pkg::MUL_W){1'b0}}, prod_ff};
      div_req.divisor  = dur_ff;
      mul_a            = count_ff;
      unique case (state_ff)
         erm_pkg::S_IDLE: begin
            req_if.ready = 1'b1;
         end
         erm_pkg::S_RATE_DIV: begin
            div_req.start = 1'b1;
         end
         erm_pkg::S_AVG_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = {{(erm_pkg::DVD_W - erm_pkg::EVENTS_W){1'b0}}, events_ff};
            div_req.divisor  = {{(erm_pkg::DVS_W - erm_pkg::RES_W){1'b0}}, msgs_ff};
         end
         erm_pkg::S_EVLO_MUL: begin
            mul_a = events_ff[erm_pkg::MUL_A_W-1:0];
         end
         erm_pkg::S_EVHI_MUL: begin
            mul_a = {{(2 * erm_pkg::MUL_A_W - erm_pkg::EVENTS_W){1'b0}},
                     events_ff[erm_pkg::EVENTS_W-1:erm_pkg::MUL_A_W]};
         end
         erm_pkg::S_AR_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = wide_ff;
            div_req.divisor  = time_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- configuration ----------------
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= erm_pkg::INTERVAL_RESET;
      end else if (csr_if.valid) begin
         interval_ff <= csr_if.wdata;
      end
   end

   // ---------------- datapath ----------------
   assign mul_p = {{erm_pkg::SCALE_W{1'b0}}, mul_a}
                * {{erm_pkg::MUL_A_W{1'b0}}, erm_pkg::SCALE};

   assign ev_sum   = {1'b0, events_ff}
                   + {{(erm_pkg::EVENTS_W + 1 - erm_pkg::COUNT_W){1'b0}}, count_ff};
   assign time_sum = {1'b0, time_ff} + {1'b0, dur_ff};
   assign gap      = (seq_ff > prev_seq_ff) ? (seq_ff - prev_seq_ff - 1'b1) : '0;
   assign drop_sum = {1'b0, drop_ff} + {1'b0, gap};
   assign restart  = (start_ff < wstart_ff);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         start_ff <= req_if.start_time_ns;
         end_ff   <= req_if.end_time_ns;
         dur_ff   <= req_if.end_time_ns - req_if.start_time_ns;
         count_ff <= req_if.event_count;
         seq_ff   <= req_if.seq_number;
      end
      if (state_ff == erm_pkg::S_RATE_MUL || state_ff == erm_pkg::S_EVLO_MUL) begin
         prod_ff <= mul_p;
      end
      if (state_ff == erm_pkg::S_EVHI_MUL) begin
         // High half of the event count lands 32 bits up.
         wide_ff <= {mul_p[erm_pkg::DVD_W-erm_pkg::MUL_A_W-1:0], {erm_pkg::MUL_A_W{1'b0}}}
                  + {{(erm_pkg::DVD_W - erm_pkg::MUL_W){1'b0}}, prod_ff};
      end
      if (state_ff == erm_pkg::S_AVG_WAIT && div_rsp.done) begin
         avg_ev_ff <= div_rsp.quotient;
      end
      if (state_ff == erm_pkg::S_AR_WAIT && div_rsp.done) begin
         avg_rate_ff <= div_rsp.quotient;
      end
      if (state_ff == erm_pkg::S_TEST) begin
         limit_ff <= limit_sum[erm_pkg::TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rate_ff <= '0;
         events_ff   <= '0;
         time_ff     <= '0;
         msgs_ff     <= '0;
         drop_ff     <= '0;
         prev_seq_ff <= '0;
         wstart_ff   <= '1;
      end else begin
         if (state_ff == erm_pkg::S_RATE_WAIT && div_rsp.done
             && div_rsp.quotient > max_rate_ff) begin
            max_rate_ff <= div_rsp.quotient;
         end
         if (state_ff == erm_pkg::S_ACCUM) begin
            events_ff   <= ev_sum[erm_pkg::EVENTS_W] ? '1 : ev_sum[erm_pkg::EVENTS_W-1:0];
            time_ff     <= time_sum[erm_pkg::TIME_W] ? '1 : time_sum[erm_pkg::TIME_W-1:0];
            msgs_ff     <= (msgs_ff == '1) ? msgs_ff : msgs_ff + 1'b1;
            prev_seq_ff <= seq_ff;
            // A message older than the window start reopens the window there.
            if (restart) begin
               wstart_ff <= start_ff;
               drop_ff   <= '0;
            end else begin
               drop_ff <= drop_sum[erm_pkg::RES_W] ? '1 : drop_sum[erm_pkg::RES_W-1:0];
            end
         end
         if (emit_fire) begin
            max_rate_ff <= '0;
            events_ff   <= '0;
            time_ff     <= '0;
            msgs_ff     <= '0;
            drop_ff     <= '0;
            wstart_ff   <= limit_ff;
         end
      end
   end

   // ---------------- report output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_avg_ev_ff   <= avg_ev_ff;
         rsp_avg_rate_ff <= avg_rate_ff;
         rsp_max_ff      <= max_rate_ff;
         rsp_drop_ff     <= drop_ff;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.avg_events_per_msg = rsp_avg_ev_ff;
   assign rsp_if.avg_rate_kevs      = rsp_avg_rate_ff;
   assign rsp_if.max_rate_kevs      = rsp_max_ff;
   assign rsp_if.dropped_count      = rsp_drop_ff;

   // ---------------- assertions ----------------
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == erm_pkg::S_RATE_WAIT || state_ff == erm_pkg::S_AVG_WAIT
                        || state_ff == erm_pkg::S_AR_WAIT))
      else $error("divider result arrived with no division pending");

   a_report_has_msgs: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> msgs_ff != '0)
      else $error("report emitted for an empty window");

   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (events_ff == '0 && msgs_ff == '0 && time_ff == '0 && rsp_valid_ff))
      else $error("window not cleared after a report");

   a_divider_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("division issued while the divider is busy");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for event_rate_monitor: directed table, then random
// message streams. Expected reports come from typed rows or a window-accounting
// predictor in this file. Needs erm_pkg, erm_ifs and the RTL of the block.
module testbench;

   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_CYCLES    = 3000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [127:0] KEVS_SCALE = 128'd1000000;

   typedef enum {CHECK_NONE, CHECK_TYPED, CHECK_MODEL} check_kind_type;

   typedef struct packed {
      logic [erm_pkg::TIME_W-1:0]  first_ns;
      logic [erm_pkg::TIME_W-1:0]  last_ns;
      logic [erm_pkg::COUNT_W-1:0] events;
      logic [erm_pkg::SEQ_W-1:0]   seq;
   } message_type;

   typedef struct packed {
      logic [erm_pkg::RES_W-1:0] avg_events;
      logic [erm_pkg::RES_W-1:0] avg_rate;
      logic [erm_pkg::RES_W-1:0] max_rate;
      logic [erm_pkg::RES_W-1:0] dropped;
   } window_report_type;

   typedef struct {
      message_type       msg;
      check_kind_type    kind;
      window_report_type want;
   } directed_row_type;

   logic clock;
   logic reset;

   erm_req_if req_if ();
   erm_rsp_if rsp_if ();
   erm_csr_if csr_if ();

   event_rate_monitor DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Window accounting state of the predictor.
   logic [erm_pkg::INTERVAL_W-1:0] cur_interval = erm_pkg::INTERVAL_RESET;
   logic [erm_pkg::RES_W-1:0]      win_max_rate = '0;
   logic [erm_pkg::EVENTS_W-1:0]   win_events   = '0;
   logic [erm_pkg::TIME_W-1:0]     win_ns       = '0;
   logic [31:0]                    win_msgs     = '0;
   logic [31:0]                    win_drops    = '0;
   logic [erm_pkg::SEQ_W-1:0]      last_seq     = '0;
   logic [erm_pkg::TIME_W-1:0]     win_start    = '1;

   // Stream generator state.
   logic [erm_pkg::TIME_W-1:0] stream_now = '0;
   logic [erm_pkg::SEQ_W-1:0]  next_seq   = '0;

   window_report_type pending_reports[$];
   directed_row_type  directed_rows[$];
   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_asked     = 0;
   int hold_given     = 0;
   int hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic log_error(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [erm_pkg::RES_W-1:0] got,
                              input logic [erm_pkg::RES_W-1:0] want);
      if (got !== want)
         log_error($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [erm_pkg::RES_W-1:0] clipped_quotient(input logic [127:0] num,
                                                                  input logic [63:0] den);
      logic [127:0] q;
      if (den == 0)
         return '0;
      q = num / {64'd0, den};
      return (q > 128'hFFFF_FFFF) ? '1 : q[erm_pkg::RES_W-1:0];
   endfunction

   // Folds one message into the window; returns 1 when it closes the window.
   function automatic bit account_message(input message_type m,
                                          output window_report_type r);
      logic [erm_pkg::TIME_W-1:0]  dur;
      logic [erm_pkg::RES_W-1:0]   rate;
      logic [127:0]                num;
      logic [erm_pkg::EVENTS_W:0]  ev_sum;
      logic [erm_pkg::TIME_W:0]    ns_sum;
      logic [32:0]                 drop_sum;
      logic [erm_pkg::TIME_W:0]    limit;
      r = '0;
      dur = m.last_ns - m.first_ns;
      num = {96'd0, m.events};
      rate = clipped_quotient(num * KEVS_SCALE, dur);
      if (rate > win_max_rate)
         win_max_rate = rate;
      ev_sum = {1'b0, win_events} + {17'd0, m.events};
      win_events = ev_sum[erm_pkg::EVENTS_W] ? '1 : ev_sum[erm_pkg::EVENTS_W-1:0];
      ns_sum = {1'b0, win_ns} + {1'b0, dur};
      win_ns = ns_sum[erm_pkg::TIME_W] ? '1 : ns_sum[erm_pkg::TIME_W-1:0];
      if (win_msgs != '1)
         win_msgs++;
      if (m.seq > last_seq) begin
         drop_sum = {1'b0, win_drops} + {1'b0, m.seq - last_seq - 32'd1};
         win_drops = drop_sum[32] ? '1 : drop_sum[31:0];
      end
      last_seq = m.seq;
      if (m.first_ns < win_start) begin
         win_start = m.first_ns;
         win_drops = '0;
      end
      // A window end beyond the top of the time range never closes.
      limit = {1'b0, win_start} + {17'd0, cur_interval};
      if (!limit[erm_pkg::TIME_W] && m.last_ns > limit[erm_pkg::TIME_W-1:0]) begin
         num = {80'd0, win_events};
         r.avg_events = clipped_quotient(num, {32'd0, win_msgs});
         r.avg_rate   = clipped_quotient(num * KEVS_SCALE, win_ns);
         r.max_rate   = win_max_rate;
         r.dropped    = win_drops;
         win_max_rate = '0;
         win_events   = '0;
         win_ns       = '0;
         win_msgs     = '0;
         win_drops    = '0;
         win_start    = limit[erm_pkg::TIME_W-1:0];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic add_row(input logic [63:0] first_ns, input logic [63:0] last_ns,
                          input logic [31:0] events, input logic [31:0] seq,
                          input check_kind_type kind, input window_report_type want);
      directed_row_type row;
      row.msg  = {first_ns, last_ns, events, seq};
      row.kind = kind;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   task automatic write_interval(input logic [erm_pkg::INTERVAL_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.wdata <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      cur_interval = value;
   endtask

   // Offers one message after a random idle gap and books its report on acceptance.
   task automatic send_message(input message_type m, input check_kind_type kind,
                               input window_report_type want);
      window_report_type predicted;
      bit closes;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.start_time_ns <= m.first_ns;
      req_if.end_time_ns   <= m.last_ns;
      req_if.event_count   <= m.events;
      req_if.seq_number    <= m.seq;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      closes = account_message(m, predicted);
      if (kind == CHECK_TYPED)
         pending_reports.push_back(want);
      else if (kind == CHECK_MODEL && closes)
         pending_reports.push_back(predicted);
   endtask

   task automatic wait_for_reports();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   // Mostly well-formed streams that advance in time and close windows often,
   // with restarts below the window start and fully random messages mixed in.
   task automatic make_message(output message_type m);
      logic [63:0] span;
      logic [63:0] gap;
      logic [63:0] dur;
      int pick;
      span = (cur_interval < 64) ? 64'd64 : 64'(cur_interval);
      if (stream_now < win_start || stream_now - win_start > span * 8)
         stream_now = win_start;
      pick = $urandom_range(99);
      if (pick < 8) begin
         m.first_ns = rand64();
         m.last_ns  = rand64();
         m.events   = $urandom;
         m.seq      = $urandom;
      end else begin
         if (pick < 13 && win_start != 0)
            stream_now = rand64() % win_start;
         gap = rand64() % (span / 4 + 1);
         dur = (pick < 17) ? 64'd0 : rand64() % (span / 2 + 1);
         m.first_ns = stream_now + gap;
         m.last_ns  = m.first_ns + dur;
         stream_now = m.last_ns;
         case ($urandom_range(3))
            0: m.events = $urandom_range(0, 100);
            1: m.events = $urandom_range(0, 100000);
            2: m.events = $urandom;
            default: m.events = $urandom_range(0, 5000);
         endcase
         case ($urandom_range(19))
            0: m.seq = $urandom;
            1, 2: m.seq = next_seq + $urandom_range(1, 40);
            3: m.seq = next_seq - 1 - $urandom_range(0, 3);
            default: m.seq = next_seq;
         endcase
         next_seq = m.seq + 1;
      end
   endtask

   task automatic run_phase(input logic [erm_pkg::INTERVAL_W-1:0] interval, input int idle_pct,
                            input int stall_pct, input bit long_hold, input bit mid_drain,
                            input int n_items);
      message_type m;
      write_interval(interval);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (long_hold)
         hold_asked <= hold_asked + 1;
      for (int i = 0; i < n_items; i++) begin
         if (mid_drain && i == n_items / 2)
            wait_for_reports();
         make_message(m);
         send_message(m, CHECK_MODEL, '0);
      end
      wait_for_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_given) begin
         rsp_if.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_given <= hold_given + 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      window_report_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            log_error("report beat with no report expected");
         end else begin
            want = pending_reports.pop_front();
            check_field("avg_events_per_msg", rsp_if.avg_events_per_msg, want.avg_events);
            check_field("avg_rate_kevs", rsp_if.avg_rate_kevs, want.avg_rate);
            check_field("max_rate_kevs", rsp_if.max_rate_kevs, want.max_rate);
            check_field("dropped_count", rsp_if.dropped_count, want.dropped);
         end
      end
   end

   // Ends the run when no beat moves on any channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
             (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TIMEOUT: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.start_time_ns = '0;
      req_if.end_time_ns   = '0;
      req_if.event_count   = '0;
      req_if.seq_number    = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.wdata         = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_interval(48'd1000);

      // Right after reset the window end would pass 2^64-1, so nothing is reported.
      add_row(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, CHECK_NONE, '0);
      // Zero duration; the window restarts at time 0.
      add_row(64'd0, 64'd0, 32'd0, 32'd0, CHECK_NONE, '0);
      add_row(64'd100, 64'd600, 32'd1000, 32'd1, CHECK_NONE, '0);
      add_row(64'd700, 64'd1100, 32'd400, 32'd5, CHECK_TYPED,
              {32'd350, 32'd1553829, 32'd2000000, 32'd3});
      // Largest count over one ns saturates the rate.
      add_row(64'd1200, 64'd1201, 32'hFFFF_FFFF, 32'd6, CHECK_NONE, '0);
      // End before start wraps the duration and saturates the window time.
      add_row(64'd1500, 64'd1499, 32'd1, 32'd6, CHECK_NONE, '0);
      add_row(64'd1600, 64'd2001, 32'd0, 32'd4, CHECK_TYPED,
              {32'd1431655765, 32'd0, 32'hFFFF_FFFF, 32'd0});
      // A large gap is counted, then cleared by the restart of this same message.
      add_row(64'd50, 64'd60, 32'd10, 32'hFFFF_FFFF, CHECK_NONE, '0);
      add_row(64'd100, 64'd1051, 32'd951, 32'd0, CHECK_TYPED,
              {32'd480, 32'd1000000, 32'd1000000, 32'd0});
      // Two large gaps saturate the drop count.
      add_row(64'd1100, 64'd1100, 32'd0, 32'hFFFF_FFFF, CHECK_NONE, '0);
      add_row(64'd1200, 64'd1300, 32'd7, 32'd0, CHECK_NONE, '0);
      add_row(64'd1400, 64'd1500, 32'd3, 32'hFFFF_FFFF, CHECK_NONE, '0);
      add_row(64'd1600, 64'd2051, 32'd0, 32'd7, CHECK_TYPED,
              {32'd2, 32'd15360, 32'd70000, 32'hFFFF_FFFF});
      add_row(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0400, 32'h8000_0000, 32'd8,
              CHECK_MODEL, '0);
      add_row(64'd3100, 64'd3101, 32'd1, 32'd9, CHECK_MODEL, '0);
      add_row(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
              CHECK_MODEL, '0);
      add_row(64'd3200, 64'd4100, 32'd12345, 32'hA5A5_A5A6, CHECK_MODEL, '0);
      add_row(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
              CHECK_MODEL, '0);
      add_row(64'd4200, 64'd5000, 32'd1000000, 32'h8000_0001, CHECK_MODEL, '0);

      foreach (directed_rows[i])
         send_message(directed_rows[i].msg, directed_rows[i].kind, directed_rows[i].want);
      wait_for_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);

      run_phase(48'd1, 0, 0, 1'b0, 1'b0, 170);
      run_phase('1, 73, 0, 1'b0, 1'b0, 170);
      run_phase(48'd0, 0, 73, 1'b0, 1'b0, 170);
      run_phase(48'd1000, 12, 12, 1'b0, 1'b1, 180);
      run_phase(48'($urandom_range(1, 100000)), 0, 0, 1'b0, 1'b0, 180);
      run_phase(48'd3000, 0, 0, 1'b1, 1'b0, 180);
      run_phase(48'({$urandom_range(0, 65535), $urandom}), 73, 0, 1'b0, 1'b0, 170);
      run_phase(48'd800, 12, 12, 1'b0, 1'b0, 180);

      if (pending_reports.size() != 0)
         log_error($sformatf("%0d reports never arrived", pending_reports.size()));
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[event_rate_monitor.f]
rtl/erm_pkg.sv
rtl/erm_ifs.sv
rtl/erm_div.sv
rtl/event_rate_monitor.sv
verif/testbench.sv
